### rtl/dzg_pkg.sv
// dzg_pkg: shared types, codes and constants of the discrete ziggurat trial core
// no dependencies
`timescale 1ns / 1ps

package dzg_pkg;

  // fixed-point formats
  localparam int FRAC_BITS  = 16;
  localparam int HW         = FRAC_BITS + 2;  // layer height q2.f
  localparam int RHW        = FRAC_BITS + 1;  // density value q1.f
  localparam int HEIGHT_MOD = 60001;
  localparam int HEIGHT_DEN = 60000;

  localparam int LAYER_ENTRIES_DEF = 8;
  localparam int MAX_X_DEF         = 64;
  localparam int OUT_DEPTH         = 10;

  localparam logic [2:0]  NUM_LAYERS_RST = 3'd7;
  localparam logic [13:0] SIGMA_RST      = 14'd435;

  typedef enum logic [1:0] {
    OP_LAYER_WR = 2'd0,
    OP_DENS_WR  = 2'd1,
    OP_TRIAL    = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_WRITTEN = 2'd0,
    ST_ACCEPT  = 2'd1,
    ST_REJECT  = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic {
    CFG_NUM_LAYERS = 1'b0,
    CFG_SIGMA      = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    status_t            status;
    logic signed [6:0]  sample;
  } result_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  idx;
    logic [5:0]  bound;
    logic [17:0] value;
    logic [15:0] lr;
    logic        sgn;
    logic [15:0] xr;
    logic        coin;
    logic [15:0] hr;
  } item_t;

endpackage

### rtl/dzg_rem_step.sv
// dzg_rem_step: eight restoring remainder steps, one input bit each
// depends on nothing but its parameters
`timescale 1ns / 1ps

module dzg_rem_step #(
  parameter int RW = 3
) (
  input  logic [RW-1:0] rem_in,
  input  logic [7:0]    bits_in,
  input  logic [RW:0]   divisor,
  output logic [RW-1:0] rem_out
);

  logic [RW-1:0] r;
  logic [RW:0]   t;

  always_comb begin
    r = rem_in;
    t = '0;
    for (int k = 7; k >= 0; k--) begin
      t = {r, bits_in[k]};
      if (t >= divisor) begin
        t = t - divisor;
      end
      r = t[RW-1:0];
    end
    rem_out = r;
  end

endmodule

### rtl/dzg_out_fifo.sv
// dzg_out_fifo: small result queue that decouples the pipeline from the consumer
// depends on dzg_pkg
`timescale 1ns / 1ps

module dzg_out_fifo #(
  parameter int DEPTH = dzg_pkg::OUT_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dzg_pkg::result_t push_data,
  output logic             out_valid,
  input  logic             out_stall,
  output dzg_pkg::result_t out_data
);
  import dzg_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  result_t       mem [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] count;
  logic          pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem[head];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == PW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

### rtl/discrete_ziggurat_gauss_trial_core.sv
// discrete_ziggurat_gauss_trial_core: top level of the ziggurat rejection trial core
// depends on dzg_pkg, dzg_rem_step, dzg_out_fifo
`timescale 1ns / 1ps

// One item per cycle enters and one result per cycle leaves while in_stall and
// out_stall are low. In the seven-stage pipeline, two stages take layer_rand
// mod m, the layer table (bounds and heights, two read ports) is read, two
// stages take x_rand mod (bound+1), the density table is read, then two
// registered multiply stages and a compare.
// Table writes happen in the same stage that reads each table, so a trial
// always sees every write that came before it. A ten-entry result queue and
// a credit count keep input flowing while results wait. Tables come out of
// reset undefined and must be loaded before trials use them.

module discrete_ziggurat_gauss_trial_core #(
  parameter int LAYER_ENTRIES = dzg_pkg::LAYER_ENTRIES_DEF,
  parameter int MAX_X         = dzg_pkg::MAX_X_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [13:0]       cfg_data,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        operation,
  input  logic [5:0]        table_index,
  input  logic [5:0]        table_bound,
  input  logic [17:0]       table_value,
  input  logic [15:0]       layer_rand,
  input  logic              sign_rand,
  input  logic [15:0]       x_rand,
  input  logic              coin_rand,
  input  logic [15:0]       height_rand,
  // output channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic signed [6:0] sample
);
  import dzg_pkg::*;

  localparam int LW = (LAYER_ENTRIES > 1) ? $clog2(LAYER_ENTRIES) : 1;
  localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int CW = $clog2(OUT_DEPTH + 1);
  localparam logic [HW-1:0] ONE_FIX = HW'(1) << FRAC_BITS;

  // configuration registers
  logic [2:0]  num_layers;
  logic [13:0] sigma_fixed;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_layers  <= NUM_LAYERS_RST;
      sigma_fixed <= SIGMA_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NUM_LAYERS: num_layers  <= cfg_data[2:0];
        CFG_SIGMA:      sigma_fixed <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective layer count: zero counts as one, saturated to one less than the table size
  logic [2:0] m_eff;
  always_comb begin
    m_eff = (num_layers == 3'd0) ? 3'd1 : num_layers;
    if (int'(m_eff) > LAYER_ENTRIES - 1) begin
      m_eff = 3'(LAYER_ENTRIES - 1);
    end
  end

  // credit count: items in flight plus results queued
  logic          in_xfer, out_xfer;
  logic [CW-1:0] pending;

  assign in_stall = (pending == CW'(OUT_DEPTH));
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + CW'(in_xfer) - CW'(out_xfer);
    end
  end

  // stage valid bits, the pipeline never holds
  logic [6:0] v;
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[5:0], in_xfer};
    end
  end

  // stage 0: captured item, upper half of layer_rand mod m
  item_t      s0;
  logic [2:0] lrem_a;

  always_ff @(posedge clk) begin
    s0 <= '{op: op_t'(operation), idx: table_index, bound: table_bound,
            value: table_value, lr: layer_rand, sgn: sign_rand, xr: x_rand,
            coin: coin_rand, hr: height_rand};
  end

  dzg_rem_step #(.RW(3)) u_lmod_hi (
    .rem_in  (3'd0),
    .bits_in (s0.lr[15:8]),
    .divisor ({1'b0, m_eff}),
    .rem_out (lrem_a)
  );

  // stage 1: finish layer pick, layer table access, height reduce
  item_t      s1;
  logic [2:0] s1_lrem;
  logic [2:0] lrem_f;
  logic [3:0] layer_hi4;
  logic [LW-1:0] lo_addr, hi_addr, lw_addr;
  logic [LW+3:0] lo_ext, hi_ext;
  logic [LW+5:0] lw_ext;
  logic [15:0]   u_c;
  logic          layer_wr;

  always_ff @(posedge clk) begin
    s1      <= s0;
    s1_lrem <= lrem_a;
  end

  dzg_rem_step #(.RW(3)) u_lmod_lo (
    .rem_in  (s1_lrem),
    .bits_in (s1.lr[7:0]),
    .divisor ({1'b0, m_eff}),
    .rem_out (lrem_f)
  );

  assign layer_hi4 = {1'b0, lrem_f} + 4'd1;
  assign lo_ext    = {{LW{1'b0}}, 1'b0, lrem_f};
  assign hi_ext    = {{LW{1'b0}}, layer_hi4};
  assign lo_addr   = lo_ext[LW-1:0];
  assign hi_addr   = hi_ext[LW-1:0];
  assign lw_ext    = {{LW{1'b0}}, s1.idx};
  assign lw_addr   = lw_ext[LW-1:0];
  assign layer_wr  = v[1] && (s1.op == OP_LAYER_WR) && (int'(s1.idx) < LAYER_ENTRIES);
  assign u_c       = (s1.hr >= 16'(HEIGHT_MOD)) ? s1.hr - 16'(HEIGHT_MOD) : s1.hr;

  // layer table: bound above height, one write and two reads
  logic [HW+5:0] layer_mem [LAYER_ENTRIES];
  logic [HW+5:0] lo_q, hi_q;

  always_ff @(posedge clk) begin
    if (layer_wr) begin
      layer_mem[lw_addr] <= {s1.bound, s1.value[HW-1:0]};
    end
    lo_q <= layer_mem[lo_addr];
    hi_q <= layer_mem[hi_addr];
  end

  // stage 2: upper half of x_rand mod (bound+1)
  item_t       s2;
  logic        s2_layer1;
  logic [15:0] s2_u;
  logic [5:0]  xrem_a;

  always_ff @(posedge clk) begin
    s2        <= s1;
    s2_layer1 <= (lrem_f == 3'd0);
    s2_u      <= u_c;
  end

  dzg_rem_step #(.RW(6)) u_xmod_hi (
    .rem_in  (6'd0),
    .bits_in (s2.xr[15:8]),
    .divisor ({1'b0, hi_q[HW+5:HW]} + 7'd1),
    .rem_out (xrem_a)
  );

  // stage 3: finish x, density table access, case selection
  item_t          s3;
  logic           s3_layer1;
  logic [15:0]    s3_u;
  logic [5:0]     s3_xrem;
  logic [5:0]     s3_blo, s3_bhi;
  logic [HW-1:0]  s3_hlo, s3_hhi;
  logic [5:0]     x_c;
  logic [XW+5:0]  dr_ext, dw_ext;
  logic [XW-1:0]  dr_addr, dw_addr;
  logic           dens_wr;
  logic           inside_c, zero_c, case1_c, case2_c;
  logic [14:0]    bhi_scaled;

  always_ff @(posedge clk) begin
    s3        <= s2;
    s3_layer1 <= s2_layer1;
    s3_u      <= s2_u;
    s3_xrem   <= xrem_a;
    s3_blo    <= lo_q[HW+5:HW];
    s3_bhi    <= hi_q[HW+5:HW];
    s3_hlo    <= lo_q[HW-1:0];
    s3_hhi    <= hi_q[HW-1:0];
  end

  dzg_rem_step #(.RW(6)) u_xmod_lo (
    .rem_in  (s3_xrem),
    .bits_in (s3.xr[7:0]),
    .divisor ({1'b0, s3_bhi} + 7'd1),
    .rem_out (x_c)
  );

  assign dr_ext     = {{XW{1'b0}}, x_c};
  assign dr_addr    = dr_ext[XW-1:0];
  assign dw_ext     = {{XW{1'b0}}, s3.idx};
  assign dw_addr    = dw_ext[XW-1:0];
  assign dens_wr    = v[3] && (s3.op == OP_DENS_WR) && (int'(s3.idx) < MAX_X);
  assign inside_c   = (x_c != 6'd0) && (x_c <= s3_blo);
  assign zero_c     = (x_c == 6'd0);
  assign bhi_scaled = {({1'b0, s3_bhi} + 7'd1), 8'd0};
  // wide layer: entirely inside sigma; narrow: entirely outside
  assign case1_c    = (bhi_scaled <= {1'b0, sigma_fixed});
  assign case2_c    = ({s3_blo, 8'd0} >= sigma_fixed);

  logic [RHW-1:0] dens_mem [MAX_X];
  logic [RHW-1:0] dens_q;

  always_ff @(posedge clk) begin
    if (dens_wr) begin
      dens_mem[dw_addr] <= s3.value[RHW-1:0];
    end
    dens_q <= dens_mem[dr_addr];
  end

  // stage 4: first products
  op_t                s4_op;
  logic               s4_sgn, s4_coin;
  logic [5:0]         s4_x;
  logic signed [7:0]  s4_xpos;
  logic               s4_inside, s4_zero, s4_case1, s4_case2, s4_xin, s4_layer1;
  logic [15:0]        s4_u;
  logic [5:0]         s4_blo, s4_bhi;
  logic [HW-1:0]      s4_hlo, s4_hhi;

  always_ff @(posedge clk) begin
    s4_op     <= s3.op;
    s4_sgn    <= s3.sgn;
    s4_coin   <= s3.coin;
    s4_x      <= x_c;
    s4_xpos   <= case1_c ? $signed({2'b0, x_c}) : $signed({2'b0, x_c}) - 8'sd1;
    s4_inside <= inside_c;
    s4_zero   <= zero_c;
    s4_case1  <= case1_c;
    s4_case2  <= case2_c;
    s4_xin    <= (int'(x_c) < MAX_X);
    s4_layer1 <= s3_layer1;
    s4_u      <= s3_u;
    s4_blo    <= s3_blo;
    s4_bhi    <= s3_bhi;
    s4_hlo    <= s3_hlo;
    s4_hhi    <= s3_hhi;
  end

  logic [HW-1:0]       top_h;
  logic [RHW-1:0]      rho;
  logic signed [HW:0]  dh, hd, ddiff_c;
  logic signed [7:0]   xd;
  logic signed [6:0]   den_c;
  logic signed [35:0]  ys_c;
  logic signed [26:0]  lnum_c;

  assign top_h   = s4_layer1 ? ONE_FIX : s4_hlo;
  assign rho     = s4_xin ? dens_q : '0;
  assign dh      = $signed({1'b0, s4_hlo}) - $signed({1'b0, s4_hhi});
  assign hd      = $signed({1'b0, s4_hhi}) - $signed({1'b0, top_h});
  assign xd      = s4_xpos - $signed({2'b0, s4_bhi});
  assign den_c   = $signed({1'b0, s4_bhi}) - $signed({1'b0, s4_blo});
  assign ddiff_c = $signed({2'b0, rho}) - $signed({1'b0, s4_hhi});
  assign ys_c    = $signed({1'b0, s4_u}) * dh;
  assign lnum_c  = hd * xd;

  // stage 5: scale by the denominators
  op_t                s5_op;
  logic               s5_sgn, s5_coin;
  logic [5:0]         s5_x;
  logic               s5_inside, s5_zero, s5_case1, s5_case2;
  logic signed [35:0] s5_ys;
  logic signed [27:0] s5_lnum;
  logic [5:0]         s5_den;
  logic signed [HW:0] s5_ddiff;

  always_ff @(posedge clk) begin
    s5_op     <= s4_op;
    s5_sgn    <= s4_sgn;
    s5_coin   <= s4_coin;
    s5_x      <= s4_x;
    s5_inside <= s4_inside;
    s5_zero   <= s4_zero;
    s5_case1  <= s4_case1;
    s5_case2  <= s4_case2;
    s5_ys     <= ys_c;
    s5_ddiff  <= ddiff_c;
    if (den_c == 7'sd0) begin
      // flat edge: line sits at minus one
      s5_lnum <= -$signed({10'd0, ONE_FIX});
      s5_den  <= 6'd1;
    end else if (den_c < 7'sd0) begin
      s5_lnum <= -28'(lnum_c);
      s5_den  <= 6'(-den_c);
    end else begin
      s5_lnum <= 28'(lnum_c);
      s5_den  <= den_c[5:0];
    end
  end

  logic signed [42:0] lhs_c;
  logic signed [44:0] rhs_c;
  logic signed [35:0] drhs_c;

  assign lhs_c  = s5_ys * $signed({1'b0, s5_den});
  assign rhs_c  = s5_lnum * $signed(17'(HEIGHT_DEN));
  assign drhs_c = s5_ddiff * $signed(17'(HEIGHT_DEN));

  // stage 6: compares and decision
  op_t                s6_op;
  logic               s6_sgn, s6_coin;
  logic [5:0]         s6_x;
  logic               s6_inside, s6_zero, s6_case1, s6_case2;
  logic signed [45:0] s6_lhs, s6_rhs;
  logic signed [35:0] s6_ys, s6_drhs;

  always_ff @(posedge clk) begin
    s6_op     <= s5_op;
    s6_sgn    <= s5_sgn;
    s6_coin   <= s5_coin;
    s6_x      <= s5_x;
    s6_inside <= s5_inside;
    s6_zero   <= s5_zero;
    s6_case1  <= s5_case1;
    s6_case2  <= s5_case2;
    s6_lhs    <= 46'(lhs_c);
    s6_rhs    <= 46'(rhs_c);
    s6_ys     <= s5_ys;
    s6_drhs   <= drhs_c;
  end

  logic    line_le, line_ge, dens_le, accept;
  result_t res;

  assign line_le = (s6_lhs <= s6_rhs);
  assign line_ge = (s6_lhs >= s6_rhs);
  assign dens_le = (s6_ys <= s6_drhs);

  always_comb begin
    if (s6_inside) begin
      accept = 1'b1;
    end else if (s6_zero) begin
      accept = !s6_coin;
    end else if (s6_case1) begin
      accept = line_le || dens_le;
    end else if (s6_case2) begin
      accept = !(line_ge || !dens_le);
    end else begin
      accept = dens_le;
    end
  end

  always_comb begin
    res.status = ST_WRITTEN;
    res.sample = 7'sd0;
    if (s6_op == OP_TRIAL) begin
      if (accept) begin
        res.status = ST_ACCEPT;
        res.sample = s6_sgn ? $signed({1'b0, s6_x}) : -$signed({1'b0, s6_x});
      end else begin
        res.status = ST_REJECT;
      end
    end
  end

  result_t head;

  dzg_out_fifo #(.DEPTH(OUT_DEPTH)) u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (v[6]),
    .push_data (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head)
  );

  assign status = head.status;
  assign sample = head.sample;

endmodule

### rtl/dzg_checker.sv
// dzg_checker: port-level assertions for the ziggurat trial core, bound to the top
// depends on dzg_pkg and discrete_ziggurat_gauss_trial_core
`timescale 1ns / 1ps

module dzg_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        status,
  input logic signed [6:0] sample
);
  import dzg_pkg::*;

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(sample))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != ST_UNUSED)
    else $error("unused status code");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_ACCEPT |-> sample == 7'sd0)
    else $error("sample nonzero without accept");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample != -7'sd64)
    else $error("sample out of range");

endmodule

bind discrete_ziggurat_gauss_trial_core dzg_checker u_dzg_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .sample    (sample)
);
